FILE: rtl/eight_bit_alu_with_status_flags_defines.svh
// Assertion macros for the eight-bit ALU with status flags.
// No dependencies; taken in by the top level with `include.
`ifndef EIGHT_BIT_ALU_WITH_STATUS_FLAGS_DEFINES_SVH
`define EIGHT_BIT_ALU_WITH_STATUS_FLAGS_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ALU8F_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ALU8F_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/alu8f_pkg.sv
// Shared types and constants for the eight-bit ALU with status flags.
// No dependencies; imported by alu8f_core and the top level.
package alu8f_pkg;

  localparam int FUNC_W  = 5;
  localparam int WORD_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int FLAGS_W = 6;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_ADD  = 5'd0;
  localparam logic [FUNC_W-1:0] FN_ADC  = 5'd1;
  localparam logic [FUNC_W-1:0] FN_SUB  = 5'd2;
  localparam logic [FUNC_W-1:0] FN_SBC  = 5'd3;
  localparam logic [FUNC_W-1:0] FN_CP   = 5'd4;
  localparam logic [FUNC_W-1:0] FN_CPC  = 5'd5;
  localparam logic [FUNC_W-1:0] FN_AND  = 5'd6;
  localparam logic [FUNC_W-1:0] FN_OR   = 5'd7;
  localparam logic [FUNC_W-1:0] FN_EOR  = 5'd8;
  localparam logic [FUNC_W-1:0] FN_COM  = 5'd9;
  localparam logic [FUNC_W-1:0] FN_NEG  = 5'd10;
  localparam logic [FUNC_W-1:0] FN_INC  = 5'd11;
  localparam logic [FUNC_W-1:0] FN_DEC  = 5'd12;
  localparam logic [FUNC_W-1:0] FN_LSR  = 5'd13;
  localparam logic [FUNC_W-1:0] FN_ASR  = 5'd14;
  localparam logic [FUNC_W-1:0] FN_ROR  = 5'd15;
  localparam logic [FUNC_W-1:0] FN_ADIW = 5'd16;
  localparam logic [FUNC_W-1:0] FN_SBIW = 5'd17;
  localparam logic [FUNC_W-1:0] FN_LAC  = 5'd18;
  localparam logic [FUNC_W-1:0] FN_LAS  = 5'd19;
  localparam logic [FUNC_W-1:0] FN_LAT  = 5'd20;

  // Flag bit positions
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_N = 2;
  localparam int FLAG_V = 3;
  localparam int FLAG_S = 4;
  localparam int FLAG_H = 5;

  localparam logic [BYTE_W-1:0] INC_OVF_VAL = 8'h80;
  localparam logic [BYTE_W-1:0] DEC_OVF_VAL = 8'h7F;

  typedef struct packed {
    logic [WORD_W-1:0]  result;
    logic               write_back;
    logic [FLAGS_W-1:0] flags;
  } alu8f_res_t;

endpackage

FILE: rtl/alu8f_core.sv
// Single-pass datapath of the eight-bit ALU: result value, write enable, new flags.
// Depends on alu8f_pkg.
module alu8f_core (
  input  logic [alu8f_pkg::FUNC_W-1:0]  func,
  input  logic [alu8f_pkg::WORD_W-1:0]  operand_a,
  input  logic [alu8f_pkg::BYTE_W-1:0]  operand_b,
  input  logic [alu8f_pkg::FLAGS_W-1:0] flags_in,
  output alu8f_pkg::alu8f_res_t         res
);
  import alu8f_pkg::*;

  logic [BYTE_W-1:0] d;
  logic              c_in;
  logic              add_cin;
  logic [BYTE_W:0]   add_sum;
  logic [BYTE_W-1:0] add_r;
  logic              add_h, add_v;
  logic [BYTE_W-1:0] sub_x, sub_y;
  logic              sub_cin, sub_chain;
  logic [BYTE_W:0]   sub_dif;
  logic [BYTE_W-1:0] sub_r;
  logic              sub_h, sub_v, sub_z;
  logic [WORD_W-1:0] word_k, word_sum, word_dif;
  logic [BYTE_W-1:0] byte_r;

  function automatic logic [FLAGS_W-1:0] pack_flags(input logic c, input logic z,
                                                    input logic n, input logic v,
                                                    input logic h);
    return {h, n ^ v, v, n, z, c};
  endfunction

  assign d    = operand_a[BYTE_W-1:0];
  assign c_in = flags_in[FLAG_C];

  // Byte adder
  assign add_cin = (func == FN_ADC) ? c_in : 1'b0;
  assign add_sum = {1'b0, d} + {1'b0, operand_b} + {{BYTE_W{1'b0}}, add_cin};
  assign add_r   = add_sum[BYTE_W-1:0];
  assign add_h   = (d[3] & operand_b[3]) | (operand_b[3] & ~add_r[3]) | (~add_r[3] & d[3]);
  assign add_v   = (d[7] & operand_b[7] & ~add_r[7]) | (~d[7] & ~operand_b[7] & add_r[7]);

  // Byte subtractor, shared by sub, sbc, cp, cpc and neg
  assign sub_x     = (func == FN_NEG) ? '0 : d;
  assign sub_y     = (func == FN_NEG) ? d : operand_b;
  assign sub_chain = (func == FN_SBC) || (func == FN_CPC);
  assign sub_cin   = sub_chain ? c_in : 1'b0;
  assign sub_dif   = {1'b0, sub_x} - {1'b0, sub_y} - {{BYTE_W{1'b0}}, sub_cin};
  assign sub_r     = sub_dif[BYTE_W-1:0];
  assign sub_h     = (~sub_x[3] & sub_y[3]) | (sub_y[3] & sub_r[3]) | (sub_r[3] & ~sub_x[3]);
  assign sub_v     = (sub_x[7] & ~sub_y[7] & ~sub_r[7]) | (~sub_x[7] & sub_y[7] & sub_r[7]);
  assign sub_z     = (sub_r == '0) & (~sub_chain | flags_in[FLAG_Z]);

  // Word add and subtract of a six-bit constant
  assign word_k   = {{(WORD_W-6){1'b0}}, operand_b[5:0]};
  assign word_sum = operand_a + word_k;
  assign word_dif = operand_a - word_k;

  always_comb begin
    byte_r         = '0;
    res.result     = '0;
    res.write_back = 1'b1;
    res.flags      = flags_in;
    case (func)
      FN_ADD, FN_ADC: begin
        res.result = {{BYTE_W{1'b0}}, add_r};
        res.flags  = pack_flags(add_sum[BYTE_W], add_r == '0, add_r[7], add_v, add_h);
      end
      FN_SUB, FN_SBC, FN_NEG: begin
        res.result = {{BYTE_W{1'b0}}, sub_r};
        res.flags  = pack_flags(sub_dif[BYTE_W], sub_z, sub_r[7], sub_v, sub_h);
      end
      FN_CP, FN_CPC: begin
        res.write_back = 1'b0;
        res.flags      = pack_flags(sub_dif[BYTE_W], sub_z, sub_r[7], sub_v, sub_h);
      end
      FN_AND, FN_OR, FN_EOR, FN_COM: begin
        case (func)
          FN_AND:  byte_r = d & operand_b;
          FN_OR:   byte_r = d | operand_b;
          FN_EOR:  byte_r = d ^ operand_b;
          default: byte_r = ~d;
        endcase
        res.result = {{BYTE_W{1'b0}}, byte_r};
        res.flags  = pack_flags((func == FN_COM) ? 1'b1 : c_in, byte_r == '0, byte_r[7],
                                1'b0, flags_in[FLAG_H]);
      end
      FN_INC: begin
        byte_r     = d + 8'd1;
        res.result = {{BYTE_W{1'b0}}, byte_r};
        res.flags  = pack_flags(c_in, byte_r == '0, byte_r[7], byte_r == INC_OVF_VAL,
                                flags_in[FLAG_H]);
      end
      FN_DEC: begin
        byte_r     = d - 8'd1;
        res.result = {{BYTE_W{1'b0}}, byte_r};
        res.flags  = pack_flags(c_in, byte_r == '0, byte_r[7], byte_r == DEC_OVF_VAL,
                                flags_in[FLAG_H]);
      end
      FN_LSR, FN_ASR, FN_ROR: begin
        case (func)
          FN_LSR:  byte_r = {1'b0, d[7:1]};
          FN_ASR:  byte_r = {d[7], d[7:1]};
          default: byte_r = {c_in, d[7:1]};
        endcase
        res.result = {{BYTE_W{1'b0}}, byte_r};
        res.flags  = pack_flags(d[0], byte_r == '0, byte_r[7], byte_r[7] ^ d[0],
                                flags_in[FLAG_H]);
      end
      FN_ADIW: begin
        res.result = word_sum;
        res.flags  = pack_flags(operand_a[15] & ~word_sum[15], word_sum == '0, word_sum[15],
                                ~operand_a[15] & word_sum[15], flags_in[FLAG_H]);
      end
      FN_SBIW: begin
        res.result = word_dif;
        res.flags  = pack_flags(~operand_a[15] & word_dif[15], word_dif == '0, word_dif[15],
                                operand_a[15] & ~word_dif[15], flags_in[FLAG_H]);
      end
      FN_LAC: res.result = {{BYTE_W{1'b0}}, operand_b & ~d};
      FN_LAS: res.result = {{BYTE_W{1'b0}}, operand_b | d};
      FN_LAT: res.result = {{BYTE_W{1'b0}}, operand_b ^ d};
      default: res.write_back = 1'b0;
    endcase
  end

endmodule

FILE: rtl/eight_bit_alu_with_status_flags.sv
// Eight-bit ALU with C, Z, N, V, S and H status flags.
// Registered path: input stage, then result stage beside the flag register.
// Throughput: one transfer per cycle while out_stall is low; the flag register updates with the result stage.
// Reset (rst_n low, synchronous): both stages emptied and all status flags cleared.
// Depends on alu8f_pkg, alu8f_core and eight_bit_alu_with_status_flags_defines.svh.
`include "eight_bit_alu_with_status_flags_defines.svh"

module eight_bit_alu_with_status_flags (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [alu8f_pkg::FUNC_W-1:0]  in_func,
  input  logic [alu8f_pkg::WORD_W-1:0]  in_operand_a,
  input  logic [alu8f_pkg::BYTE_W-1:0]  in_operand_b,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [alu8f_pkg::WORD_W-1:0]  out_result,
  output logic                          out_write_back,
  output logic [alu8f_pkg::FLAGS_W-1:0] out_flags
);
  import alu8f_pkg::*;

  // Input stage
  logic              s1_valid_r, s1_valid_nxt;
  logic [FUNC_W-1:0] s1_func_r;
  logic [WORD_W-1:0] s1_a_r;
  logic [BYTE_W-1:0] s1_b_r;

  // Result stage and architectural flags
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_result_r;
  logic               out_wb_r;
  logic [FLAGS_W-1:0] flags_r;

  alu8f_res_t core_res;
  logic       adv;
  logic       s1_load;
  logic       s1_cmp;
  logic       s1_word;

  // Advance the held item into the result register when that register is empty
  // or its contents leave in this cycle. The flag register updates on the same
  // edge, so the next item always sees the flags left by its predecessor.
  assign adv      = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~adv;
  assign s1_load  = ~in_stall;

  // Operation classes of the held item, used by the checks below
  assign s1_cmp  = (s1_func_r == FN_CP) || (s1_func_r == FN_CPC);
  assign s1_word = (s1_func_r == FN_ADIW) || (s1_func_r == FN_SBIW);

  alu8f_core u_core (
    .func      (s1_func_r),
    .operand_a (s1_a_r),
    .operand_b (s1_b_r),
    .flags_in  (flags_r),
    .res       (core_res)
  );

  always_comb begin
    // Take a new item whenever the input register is free or draining.
    s1_valid_nxt = s1_load ? in_valid : s1_valid_r;
    // Hold a stalled result; drop it once transferred with nothing behind it.
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        flags_r <= core_res.flags;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_func_r <= in_func;
      s1_a_r    <= in_operand_a;
      s1_b_r    <= in_operand_b;
    end
    if (adv) begin
      out_result_r <= core_res.result;
      out_wb_r     <= core_res.write_back;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result     = out_result_r;
  assign out_write_back = out_wb_r;
  assign out_flags      = flags_r;

  // The flag register moves only when an item passes into the result stage.
  `ALU8F_ASSERT_NEXT(a_flags_hold, clk, rst_n, !adv, $stable(flags_r), "flags moved while idle")
  // An advance always leaves a valid result behind.
  `ALU8F_ASSERT_NEXT(a_adv_valid, clk, rst_n, adv, out_valid, "advance without result")
  // Compares never write back.
  `ALU8F_ASSERT_NEXT(a_cmp_no_wb, clk, rst_n, adv && s1_cmp, !out_write_back, "compare stored")
  // Byte operations leave the high byte clear.
  `ALU8F_ASSERT_NEXT(a_byte_hi, clk, rst_n, adv && !s1_word, ~|out_result[15:8], "high byte set")

endmodule

FILE: sim/tb_eight_bit_alu_with_status_flags.sv
// Self-checking testbench for the eight-bit ALU with status flags.
// Depends on alu8f_pkg and the eight_bit_alu_with_status_flags top level only.
`timescale 1ns / 100ps

module tb_eight_bit_alu_with_status_flags;
  import alu8f_pkg::*;

  // Codes past the last defined operation; the block must treat them as no-ops
  localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 5'd21;
  localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 5'd31;

  localparam int RANDOM_OPS  = 1300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_AFTER  = 400;   // transfers in before the long receiver hold
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_WAIT  = 8;     // extra wait after the last expected result

  typedef struct packed {
    logic [FUNC_W-1:0] fn;
    logic [WORD_W-1:0] a;
    logic [BYTE_W-1:0] b;
  } alu_op_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FUNC_W-1:0]    in_func = '0;
  logic [WORD_W-1:0]    in_operand_a = '0;
  logic [BYTE_W-1:0]    in_operand_b = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WORD_W-1:0]    out_result;
  logic                 out_write_back;
  logic [FLAGS_W-1:0]   out_flags;

  alu_op_t      op_pending[$];     // operations still to be offered
  alu8f_res_t   alu_expected[$];   // predicted results, oldest first
  logic [FLAGS_W-1:0] sreg_model = '0;

  int ops_total    = 0;
  int ops_taken    = 0;
  int res_seen     = 0;
  int mismatch_cnt = 0;
  int hold_left    = 0;
  int cycle_cnt    = 0;

  eight_bit_alu_with_status_flags i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_operand_a   (in_operand_a),
    .in_operand_b   (in_operand_b),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result     (out_result),
    .out_write_back (out_write_back),
    .out_flags      (out_flags)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Flag predictor. Assemble the six status bits; S always follows N xor V.
  // ---------------------------------------------------------------------------
  function automatic logic [FLAGS_W-1:0] sreg_pack(logic c, logic z, logic n, logic v,
                                                   logic h);
    logic [FLAGS_W-1:0] f;
    f = '0;
    f[FLAG_C] = c;
    f[FLAG_Z] = z;
    f[FLAG_N] = n;
    f[FLAG_V] = v;
    f[FLAG_S] = n ^ v;
    f[FLAG_H] = h;
    return f;
  endfunction

  // Byte addition flags; half carry taken out of bit 3
  function automatic logic [FLAGS_W-1:0] add_sreg(logic [7:0] d, logic [7:0] r, logic cin);
    logic [8:0] sum;
    logic [7:0] s;
    sum = {1'b0, d} + {1'b0, r} + {8'd0, cin};
    s   = sum[7:0];
    return sreg_pack(sum[8], s == 8'h00, s[7],
                     (d[7] & r[7] & ~s[7]) | (~d[7] & ~r[7] & s[7]),
                     (d[3] & r[3]) | (r[3] & ~s[3]) | (~s[3] & d[3]));
  endfunction

  // Byte subtraction flags; zin is the old Z for carry-chained forms, else 1,
  // so a chained zero only holds Z if the lower bytes were zero too
  function automatic logic [FLAGS_W-1:0] sub_sreg(logic [7:0] d, logic [7:0] r, logic cin,
                                                  logic zin);
    logic [8:0] dif;
    logic [7:0] s;
    dif = {1'b0, d} - {1'b0, r} - {8'd0, cin};
    s   = dif[7:0];
    return sreg_pack(dif[8], (s == 8'h00) & zin, s[7],
                     (d[7] & ~r[7] & ~s[7]) | (~d[7] & r[7] & s[7]),
                     (~d[3] & r[3]) | (r[3] & s[3]) | (s[3] & ~d[3]));
  endfunction

  // Work out the whole result of one operation against the current flags
  function automatic alu8f_res_t alu_expect(logic [FUNC_W-1:0] fn, logic [WORD_W-1:0] a16,
                                            logic [BYTE_W-1:0] r, logic [FLAGS_W-1:0] sr);
    alu8f_res_t  e;
    logic [7:0]  d;
    logic [7:0]  y;
    logic [15:0] w;
    logic [5:0]  k;
    logic        cin;
    d   = a16[7:0];
    cin = sr[FLAG_C];
    k   = r[5:0];   // word constant: low six bits only
    y   = 8'h00;
    w   = '0;
    e.result     = '0;
    e.write_back = 1'b1;
    e.flags      = sr;
    case (fn)
      FN_ADD: begin
        y = d + r;
        e.flags = add_sreg(d, r, 1'b0);
      end
      FN_ADC: begin
        y = d + r + cin;
        e.flags = add_sreg(d, r, cin);
      end
      FN_SUB: begin
        y = d - r;
        e.flags = sub_sreg(d, r, 1'b0, 1'b1);
      end
      FN_SBC: begin
        y = d - r - cin;
        e.flags = sub_sreg(d, r, cin, sr[FLAG_Z]);
      end
      FN_CP: begin
        e.write_back = 1'b0;
        e.flags = sub_sreg(d, r, 1'b0, 1'b1);
      end
      FN_CPC: begin
        e.write_back = 1'b0;
        e.flags = sub_sreg(d, r, cin, sr[FLAG_Z]);
      end
      FN_AND: begin
        y = d & r;
        e.flags = sreg_pack(sr[FLAG_C], y == 8'h00, y[7], 1'b0, sr[FLAG_H]);
      end
      FN_OR: begin
        y = d | r;
        e.flags = sreg_pack(sr[FLAG_C], y == 8'h00, y[7], 1'b0, sr[FLAG_H]);
      end
      FN_EOR: begin
        y = d ^ r;
        e.flags = sreg_pack(sr[FLAG_C], y == 8'h00, y[7], 1'b0, sr[FLAG_H]);
      end
      FN_COM: begin
        y = ~d;
        e.flags = sreg_pack(1'b1, y == 8'h00, y[7], 1'b0, sr[FLAG_H]);
      end
      FN_NEG: begin
        y = 8'h00 - d;
        e.flags = sub_sreg(8'h00, d, 1'b0, 1'b1);
      end
      FN_INC: begin
        y = d + 8'h01;
        e.flags = sreg_pack(sr[FLAG_C], y == 8'h00, y[7], y == INC_OVF_VAL, sr[FLAG_H]);
      end
      FN_DEC: begin
        y = d - 8'h01;
        e.flags = sreg_pack(sr[FLAG_C], y == 8'h00, y[7], y == DEC_OVF_VAL, sr[FLAG_H]);
      end
      FN_LSR: begin
        y = {1'b0, d[7:1]};
        e.flags = sreg_pack(d[0], y == 8'h00, y[7], y[7] ^ d[0], sr[FLAG_H]);
      end
      FN_ASR: begin
        y = {d[7], d[7:1]};
        e.flags = sreg_pack(d[0], y == 8'h00, y[7], y[7] ^ d[0], sr[FLAG_H]);
      end
      FN_ROR: begin
        y = {cin, d[7:1]};
        e.flags = sreg_pack(d[0], y == 8'h00, y[7], y[7] ^ d[0], sr[FLAG_H]);
      end
      FN_ADIW: begin
        w = a16 + {10'd0, k};
        e.flags = sreg_pack(a16[15] & ~w[15], w == 16'h0000, w[15], ~a16[15] & w[15],
                            sr[FLAG_H]);
      end
      FN_SBIW: begin
        w = a16 - {10'd0, k};
        e.flags = sreg_pack(~a16[15] & w[15], w == 16'h0000, w[15], a16[15] & ~w[15],
                            sr[FLAG_H]);
      end
      // Memory bit operations: new memory byte out, flags untouched
      FN_LAC: y = r & ~d;
      FN_LAS: y = r | d;
      FN_LAT: y = r ^ d;
      default: e.write_back = 1'b0;   // unused codes: nothing stored, flags held
    endcase
    if (fn == FN_ADIW || fn == FN_SBIW) e.result = w;
    else e.result = {8'h00, y};
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_op(logic [FUNC_W-1:0] fn, logic [WORD_W-1:0] a, logic [BYTE_W-1:0] b);
    alu_op_t op;
    op.fn = fn;
    op.a  = a;
    op.b  = b;
    op_pending.push_back(op);
  endtask

  // Favour the byte values where carries, overflows and zeros turn over
  function automatic logic [7:0] byte_pick();
    case ($urandom_range(0, 11))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h7F;
      3: return 8'h80;
      4: return 8'hFF;
      5: return 8'h0F;
      6: return 8'h10;
      7: return 8'hFE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] word_pick();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'hFFFF;
      5: return 16'h003F;
      6: return 16'h7FC1;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Idle length: mostly none, often short, now and then long; quiet runs of
  // back-to-back cycles are started at random through the caller's counter
  function automatic int idle_draw(inout int quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if (r < 2) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_cnt++;
    $display("[%0t] result %0d: %s", $time, res_seen, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offer the next pending operation, hold it while stalled, and
  // predict its result at the edge where the transfer happens.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : tx_side
    int         tx_gap;
    int         tx_quiet;
    logic       nv;
    alu_op_t    op;
    alu8f_res_t want;
    if (!rst_n) begin
      tx_gap   = 0;
      tx_quiet = 0;
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && !in_stall) begin
        want = alu_expect(in_func, in_operand_a, in_operand_b, sreg_model);
        sreg_model = want.flags;
        alu_expected.push_back(want);
        ops_taken <= ops_taken + 1;
        nv = 1'b0;
      end
      // Only move on once the current payload has gone; a stalled one stays put
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (op_pending.size() != 0) begin
          op = op_pending.pop_front();
          in_func      <= op.fn;
          in_operand_a <= op.a;
          in_operand_b <= op.b;
          nv     = 1'b1;
          tx_gap = idle_draw(tx_quiet);
        end
      end
      in_valid <= nv;
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold, counted here on its own: once enough has gone in, keep
  // the output stalled so the pipeline fills and pushes back on the sender.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : hold_ctl
    bit hold_done;
    if (!rst_n) begin
      hold_done = 1'b0;
      hold_left <= 0;
    end else if (!hold_done && ops_taken >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: check each transfer out against the oldest prediction, then
  // pick the stall for the next cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : rx_side
    int         rx_left;
    int         rx_quiet;
    logic       ns;
    alu8f_res_t want;
    if (!rst_n) begin
      rx_left  = 0;
      rx_quiet = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (alu_expected.size() == 0) begin
          note_mismatch("result with nothing outstanding");
        end else begin
          want = alu_expected.pop_front();
          if (out_result !== want.result)
            note_mismatch($sformatf("result got %h expected %h", out_result, want.result));
          if (out_write_back !== want.write_back)
            note_mismatch($sformatf("write_back got %b expected %b",
                                    out_write_back, want.write_back));
          if (out_flags !== want.flags)
            note_mismatch($sformatf("flags got %b expected %b", out_flags, want.flags));
        end
        res_seen++;
      end
      if (hold_left > 0) begin
        ns = 1'b1;
      end else if (rx_left > 0) begin
        rx_left--;
        ns = 1'b1;
      end else begin
        rx_left = idle_draw(rx_quiet);
        ns = (rx_left > 0);
        if (ns) rx_left--;
      end
      out_stall <= ns;
    end
  end

  // Cap the run in case the handshake locks up
  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Fill the pending queue, release reset, then wait for everything to drain.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int n;
    int k;
    int r;
    logic [FUNC_W-1:0] fn;

    // Directed: every operation at least once, with operands at the flag corners.
    // Order matters: each one leans on the flags the one before leaves.
    queue_op(FN_ADD,  16'h00FF, 8'h01);   // wrap to zero: C, Z, H
    queue_op(FN_ADC,  16'h007F, 8'h00);   // carry in pushes into the sign bit
    queue_op(FN_SUB,  16'h0000, 8'h01);   // borrow out of zero
    queue_op(FN_SBC,  16'h0080, 8'h7F);   // zero result, but Z was clear
    queue_op(FN_CP,   16'h0055, 8'h55);   // equal compare, nothing stored
    queue_op(FN_CPC,  16'h0000, 8'h00);   // chained compare keeps Z
    queue_op(FN_AND,  16'hFFFF, 8'h00);
    queue_op(FN_OR,   16'h0080, 8'h7F);
    queue_op(FN_EOR,  16'h00AA, 8'h55);
    queue_op(FN_COM,  16'h0000, 8'h00);
    queue_op(FN_NEG,  16'h0080, 8'h00);   // negating the most negative byte
    queue_op(FN_INC,  16'h007F, 8'h00);   // signed overflow on increment
    queue_op(FN_DEC,  16'h0080, 8'h00);   // signed overflow on decrement
    queue_op(FN_LSR,  16'h0001, 8'h00);
    queue_op(FN_ASR,  16'h0081, 8'h00);
    queue_op(FN_ROR,  16'h0000, 8'h00);   // carry rotates into bit 7
    queue_op(FN_ADIW, 16'hFFFF, 8'hFF);   // only the low six bits of the constant
    queue_op(FN_SBIW, 16'h0000, 8'h3F);   // word borrow
    queue_op(FN_SBIW, 16'h8000, 8'hC1);   // word overflow, upper bits ignored
    queue_op(FN_ADIW, 16'h7FFF, 8'h01);   // word overflow into the sign bit
    queue_op(FN_LAC,  16'h000F, 8'hFF);   // memory bit clear
    queue_op(FN_LAS,  16'h00F0, 8'h0F);   // memory bit set
    queue_op(FN_LAT,  16'hFFFF, 8'hAA);   // memory bit toggle; high byte ignored
    queue_op(FN_UNUSED_LO, 16'hFFFF, 8'hFF);
    queue_op(FN_UNUSED_HI, 16'h1234, 8'h56);

    // Random: mostly lone operations, with a good share of multi-byte chains
    // so the carry and sticky-zero paths see real sequences
    n = op_pending.size() + RANDOM_OPS;
    while (op_pending.size() < n) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        k = $urandom_range(1, 3);
        case ($urandom_range(0, 3))
          0: begin
            queue_op(FN_ADD, {8'($urandom_range(0, 255)), byte_pick()}, byte_pick());
            repeat (k) queue_op(FN_ADC, {8'($urandom_range(0, 255)), byte_pick()},
                                byte_pick());
          end
          1: begin
            queue_op(FN_SUB, {8'($urandom_range(0, 255)), byte_pick()}, byte_pick());
            repeat (k) queue_op(FN_SBC, {8'($urandom_range(0, 255)), byte_pick()},
                                byte_pick());
          end
          2: begin
            queue_op(FN_CP, {8'($urandom_range(0, 255)), byte_pick()}, byte_pick());
            repeat (k) queue_op(FN_CPC, {8'($urandom_range(0, 255)), byte_pick()},
                                byte_pick());
          end
          default: begin
            repeat (k + 1) begin
              fn = ($urandom_range(0, 1) != 0) ? FN_ADIW : FN_SBIW;
              queue_op(fn, word_pick(), 8'($urandom_range(0, 255)));
            end
          end
        endcase
      end else begin
        if (r < 92) fn = FUNC_W'($urandom_range(FN_ADD, FN_LAT));
        else fn = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
        if (fn == FN_ADIW || fn == FN_SBIW)
          queue_op(fn, word_pick(), 8'($urandom_range(0, 255)));
        else
          queue_op(fn, {8'($urandom_range(0, 255)), byte_pick()}, byte_pick());
      end
    end
    ops_total = op_pending.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (ops_taken < ops_total) @(posedge clk);
    while (alu_expected.size() != 0) @(posedge clk);
    // Allow any stray result to surface before closing
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
